@@ sv/wavdec_pkg.sv @@
// Package: shared types and constants of the WAV PCM stream decoder.
package wavdec_pkg;

   localparam logic [31:0] TAG_RIFF = 32'h52494646;
   localparam logic [31:0] TAG_WAVE = 32'h57415645;
   localparam logic [31:0] TAG_FMT  = 32'h666D7420;
   localparam logic [31:0] TAG_DATA = 32'h64617461;
   localparam logic [31:0] MIN_FILE_BYTES = 32'd44;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SHORT     = 3'd1;
   localparam logic [2:0] ST_NO_RIFF   = 3'd2;
   localparam logic [2:0] ST_NO_WAVE   = 3'd3;
   localparam logic [2:0] ST_NON_PCM   = 3'd4;
   localparam logic [2:0] ST_MISSING   = 3'd5;
   localparam logic [2:0] ST_BAD_DEPTH = 3'd6;
   localparam logic [2:0] ST_DATA_1ST  = 3'd7;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic        kind;
      logic [31:0] sample;
      logic [15:0] channels;
      logic [31:0] sample_rate;
      logic [31:0] sample_count;
      logic [2:0]  status;
      logic        last;
   } result_type;

   // one queue entry: up to two results caused by one byte
   typedef struct packed {
      logic       has_smp;
      logic       has_sum;
      result_type smp;
      result_type sum;
   } entry_type;

endpackage

@@ sv/wavdec_front.sv @@
// Front end: header and chunk parser, sample assembly, one entry per byte.
module wavdec_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [7:0]             in_byte,
   input  logic                   in_eof,
   output logic                   in_ready,
   output logic                   ent_valid,
   output wavdec_pkg::entry_type  ent,
   input  logic                   ent_ready
);

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_CHEAD  = 3'd1;
   localparam logic [2:0] PH_FMT    = 3'd2;
   localparam logic [2:0] PH_DATA   = 3'd3;
   localparam logic [2:0] PH_SKIP   = 3'd4;
   localparam logic [2:0] PH_PAD    = 3'd5;
   localparam logic [2:0] PH_ERROR  = 3'd6;

   logic [31:0] pos_ff, pos_in;
   logic [2:0]  phase_ff, phase_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] rem_ff, rem_in;
   logic        pad_ff, pad_in;
   logic [15:0] fmtc_ff, fmtc_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bps_ff, bps_in;
   logic [31:0] asm_ff, asm_in;
   logic [1:0]  nib_ff, nib_in;
   logic [31:0] cnt_ff, cnt_in;
   logic        seen_ff, seen_in;
   logic [2:0]  err_ff, err_in;
   logic [4:0]  fidx_ff, fidx_in;

   logic        take;
   logic        smp_hit;
   logic [31:0] smp_val;
   logic [31:0] rem_dec;
   logic [31:0] asm_or;
   logic [2:0]  width;
   logic [2:0]  sum_st;
   logic [31:0] pos_nx;

   assign in_ready = ent_ready;
   assign take     = in_valid && in_ready;
   assign rem_dec  = rem_ff - 32'd1;
   assign width    = bps_ff[5:3];

   always_comb begin
      pos_in = pos_ff; phase_in = phase_ff; tag_in = tag_ff; rem_in = rem_ff;
      pad_in = pad_ff; fmtc_in = fmtc_ff; chan_in = chan_ff; rate_in = rate_ff;
      bps_in = bps_ff; asm_in = asm_ff; nib_in = nib_ff; cnt_in = cnt_ff;
      seen_in = seen_ff; err_in = err_ff; fidx_in = fidx_ff;
      smp_hit = 1'b0; smp_val = '0; sum_st = wavdec_pkg::ST_OK;
      asm_or = asm_ff | ({24'd0, in_byte} << {nib_ff, 3'b000});
      unique case (phase_ff)
         PH_HEADER: begin
            tag_in = {tag_ff[23:0], in_byte};
            if (pos_ff == 32'd3 && tag_in != wavdec_pkg::TAG_RIFF) begin
               err_in = wavdec_pkg::ST_NO_RIFF; phase_in = PH_ERROR;
            end else if (pos_ff == 32'd11) begin
               if (tag_in != wavdec_pkg::TAG_WAVE) begin
                  err_in = wavdec_pkg::ST_NO_WAVE; phase_in = PH_ERROR;
               end else begin
                  phase_in = PH_CHEAD; fidx_in = '0;
               end
            end
         end
         PH_CHEAD: begin
            if (fidx_ff < 5'd4) begin
               tag_in = {tag_ff[23:0], in_byte};
               if (fidx_ff == 5'd0) rem_in = '0;
            end else begin
               rem_in = rem_ff | ({24'd0, in_byte} << {fidx_ff[1:0], 3'b000});
            end
            fidx_in = fidx_ff + 5'd1;
            if (fidx_ff == 5'd7) begin
               pad_in = rem_in[0];
               // tag_ff holds all four tag bytes by now
               if (tag_ff == wavdec_pkg::TAG_FMT && rem_in >= 32'd16 && !seen_ff) begin
                  phase_in = PH_FMT; fidx_in = '0;
               end else if (tag_ff == wavdec_pkg::TAG_DATA) begin
                  if (fmtc_ff != 16'd1) begin
                     err_in = wavdec_pkg::ST_DATA_1ST; phase_in = PH_ERROR;
                  end else if (chan_ff == '0 || rate_ff == '0) begin
                     err_in = wavdec_pkg::ST_MISSING; phase_in = PH_ERROR;
                  end else if (bps_ff != 16'd8 && bps_ff != 16'd16 &&
                               bps_ff != 16'd24 && bps_ff != 16'd32) begin
                     err_in = wavdec_pkg::ST_BAD_DEPTH; phase_in = PH_ERROR;
                  end else begin
                     seen_in = 1'b1; nib_in = '0; asm_in = '0; phase_in = PH_DATA;
                  end
               end else begin
                  phase_in = PH_SKIP;
               end
               if (phase_in != PH_ERROR && rem_in == '0) begin
                  phase_in = rem_in[0] ? PH_PAD : PH_CHEAD; fidx_in = '0;
               end
            end
         end
         PH_FMT, PH_DATA, PH_SKIP: begin
            rem_in = rem_dec;
            if (phase_ff == PH_FMT) begin
               case (fidx_ff)
                  5'd0: fmtc_in = {8'd0, in_byte};
                  5'd1: begin
                     fmtc_in = {in_byte, fmtc_ff[7:0]};
                     if (fmtc_in != 16'd1) begin
                        err_in = wavdec_pkg::ST_NON_PCM; phase_in = PH_ERROR;
                     end
                  end
                  5'd2: chan_in = {8'd0, in_byte};
                  5'd3: chan_in = {in_byte, chan_ff[7:0]};
                  5'd4: rate_in = {24'd0, in_byte};
                  5'd5: rate_in = {rate_ff[31:16], in_byte, rate_ff[7:0]};
                  5'd6: rate_in = {rate_ff[31:24], in_byte, rate_ff[15:0]};
                  5'd7: rate_in = {in_byte, rate_ff[23:0]};
                  5'd14: bps_in = {8'd0, in_byte};
                  5'd15: bps_in = {in_byte, bps_ff[7:0]};
                  default: ;
               endcase
               if (fidx_ff < 5'd16) fidx_in = fidx_ff + 5'd1;
            end else if (phase_ff == PH_DATA) begin
               if ({1'b0, nib_ff} + 3'd1 == width) begin
                  smp_hit = 1'b1;
                  case (width)
                     3'd1: smp_val = {asm_or[7:0] ^ 8'h80, 24'd0};
                     3'd2: smp_val = {asm_or[15:0], 16'd0};
                     3'd3: smp_val = {asm_or[23:0], 8'd0};
                     default: smp_val = asm_or;
                  endcase
                  asm_in = '0; nib_in = '0; cnt_in = cnt_ff + 32'd1;
               end else begin
                  asm_in = asm_or; nib_in = nib_ff + 2'd1;
               end
            end
            if (phase_in != PH_ERROR && rem_dec == '0) begin
               phase_in = pad_ff ? PH_PAD : PH_CHEAD; fidx_in = '0;
            end
         end
         PH_PAD: begin
            phase_in = PH_CHEAD; fidx_in = '0;
         end
         default: ;
      endcase
      pos_nx = (pos_ff != 32'hFFFF_FFFF) ? pos_ff + 32'd1 : pos_ff;
      pos_in = pos_nx;
      if (pos_nx < wavdec_pkg::MIN_FILE_BYTES) sum_st = wavdec_pkg::ST_SHORT;
      else if (err_in != wavdec_pkg::ST_OK)    sum_st = err_in;
      else if (!seen_in)                       sum_st = wavdec_pkg::ST_MISSING;
   end

   always_comb begin
      ent_valid = take;
      ent.has_smp = smp_hit;
      ent.has_sum = in_eof;
      ent.smp = '0;
      ent.smp.sample = smp_val;
      ent.smp.last = !in_eof;
      ent.sum = '0;
      ent.sum.kind = 1'b1;
      ent.sum.channels = chan_in;
      ent.sum.sample_rate = rate_in;
      ent.sum.sample_count = cnt_in;
      ent.sum.status = sum_st;
      ent.sum.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset || (take && in_eof)) begin
         pos_ff <= '0; phase_ff <= PH_HEADER; tag_ff <= '0; rem_ff <= '0;
         pad_ff <= 1'b0; fmtc_ff <= '0; chan_ff <= '0; rate_ff <= '0;
         bps_ff <= '0; asm_ff <= '0; nib_ff <= '0; cnt_ff <= '0;
         seen_ff <= 1'b0; err_ff <= wavdec_pkg::ST_OK; fidx_ff <= '0;
      end else if (take) begin
         pos_ff <= pos_in; phase_ff <= phase_in; tag_ff <= tag_in; rem_ff <= rem_in;
         pad_ff <= pad_in; fmtc_ff <= fmtc_in; chan_ff <= chan_in; rate_ff <= rate_in;
         bps_ff <= bps_in; asm_ff <= asm_in; nib_ff <= nib_in; cnt_ff <= cnt_in;
         seen_ff <= seen_in; err_ff <= err_in; fidx_ff <= fidx_in;
      end
   end

`ifndef SYNTH
   a_err_phase: assert property (@(posedge clock) disable iff (reset)
      (err_ff != wavdec_pkg::ST_OK) |-> (phase_ff == PH_ERROR))
      else $error("error code set outside error phase");
   a_fidx_sat: assert property (@(posedge clock) disable iff (reset)
      fidx_ff <= 5'd16) else $error("field index overrun");
   a_no_smp_err: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ERROR) |-> !smp_hit) else $error("sample after error");
`endif

endmodule

@@ sv/wavdec_back.sv @@
// Back end: entry queue and result serialiser onto the output stream.
module wavdec_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   ent_valid,
   input  wavdec_pkg::entry_type  ent,
   output logic                   ent_ready,
   output logic                   out_valid,
   output wavdec_pkg::result_type out_res,
   input  logic                   out_ready
);

   wavdec_pkg::entry_type mem_ff [wavdec_pkg::QUEUE_DEPTH];
   logic [wavdec_pkg::QPTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [wavdec_pkg::QPTR_W:0]   fill_ff, fill_in;
   logic                          half_ff, half_in;
   logic                          push, pop, useful;
   wavdec_pkg::entry_type         head;

   assign useful    = ent.has_smp || ent.has_sum;
   assign ent_ready = fill_ff != (wavdec_pkg::QPTR_W+1)'(wavdec_pkg::QUEUE_DEPTH);
   assign push      = ent_valid && ent_ready && useful;
   assign head      = mem_ff[rp_ff];
   assign out_valid = fill_ff != '0;

   always_comb begin
      if (head.has_smp && !half_ff) out_res = head.smp;
      else                          out_res = head.sum;
      pop = out_valid && out_ready &&
            (half_ff || !(head.has_smp && head.has_sum));
      half_in = half_ff;
      if (out_valid && out_ready) half_in = !pop;
      wp_in = push ? wp_ff + 1'b1 : wp_ff;
      rp_in = pop ? rp_ff + 1'b1 : rp_ff;
      fill_in = fill_ff + {{wavdec_pkg::QPTR_W{1'b0}}, push}
                        - {{wavdec_pkg::QPTR_W{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= ent;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; fill_ff <= '0; half_ff <= 1'b0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; fill_ff <= fill_in; half_ff <= half_in;
      end
   end

`ifndef SYNTH
   a_fill: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (wavdec_pkg::QPTR_W+1)'(wavdec_pkg::QUEUE_DEPTH))
      else $error("queue overfill");
   a_half: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> out_valid) else $error("split state with empty queue");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
`endif

endmodule

@@ sv/wav_pcm_stream_decoder_top.sv @@
// Top level: WAV PCM stream decoder.
// Usage:
//  req_ channel takes one file byte per beat; req_tlast marks the last byte of
//  a file. req_tdata[7:0] is the byte.
//  rsp_ channel gives samples (tuser=0) and an end-of-file summary (tuser=1).
//  A byte gives at most a sample and a summary; rsp_tlast marks the last
//  result of the byte.
//  Throughput: one byte per cycle. The front parser takes a byte each cycle
//  while the four-entry queue has room; the back end drains one result per
//  cycle while rsp_tready is high, so a byte that gives two results is sent
//  as two beats; a result is registered in the queue as its byte is taken.
//  A stalled receiver fills the queue; req_tready then drops until a slot
//  frees. Bytes that yield nothing take no queue slot.
//  Reset clears parser state and empties the queue; after a summary the parser
//  is back in its reset state for the next file.
//  rsp_tdata: sample[31:0], channels[47:32], sample_rate[79:48],
//  sample_count[111:80], status[114:112], zero fill to 120 bits.
module wav_pcm_stream_decoder_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte[7:0]
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // sample, channels, sample_rate, sample_count, status
   output logic         rsp_tuser,   // kind
   output logic         rsp_tlast
);

   logic                   ent_valid, ent_ready;
   wavdec_pkg::entry_type  ent;
   wavdec_pkg::result_type res;

   wavdec_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_byte(req_tdata), .in_eof(req_tlast),
      .in_ready(req_tready),
      .ent_valid, .ent, .ent_ready
   );

   wavdec_back u_back (
      .clock, .reset,
      .ent_valid, .ent, .ent_ready,
      .out_valid(rsp_tvalid), .out_res(res), .out_ready(rsp_tready)
   );

   assign rsp_tdata = {5'd0, res.status, res.sample_count, res.sample_rate,
                       res.channels, res.sample};
   assign rsp_tuser = res.kind;
   assign rsp_tlast = res.last;

endmodule
